[rtl/lidd_pkg.sv]
package lidd_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_DELETE     = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        empty;
        logic        dropped;
    } out_beat_t;

    // Slot arithmetic of the ring: both operands below CAPACITY.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == '0) begin
            r = ADDR_W'(CAPACITY - 1);
        end else begin
            r = a - ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

[rtl/list_insert_delete_dump.sv]
// Ordered list of signed 32-bit values, up to CAPACITY entries, in a ring buffer.
// Input beat (s_*): one command, cmd 0 push front, 1 push back, 2 delete at
// position, 3 no change. s_tready is high only while the block is idle.
// Output beats (m_*): after each command the whole list is sent front to back,
// m_tlast on the final beat; an empty list sends one beat with list_empty set.
// insert_dropped is set on every beat of a dump whose insert hit a full store.
// Flow: push front and delete of the front entry move the ring pointer directly;
// push back writes behind the last entry. Other deletes walk the entries behind
// the removed one through the memory read and write ports, one entry a cycle.
// The dump then reads one entry a cycle through the read port while the output
// buffer has room; m_tvalid rises once the first read lands in that buffer.
// Results sit in a two-beat output buffer, so the block takes the next command
// while the tail of a dump is still waiting; a stalled m_tready pauses memory
// reads without losing beats.
// Reset (aresetn low, synchronous) empties the list and drops buffered beats.
module list_insert_delete_dump
    import lidd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] cmd, [33:2] operand, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] entry_value
    output logic        m_tlast,   // last_of_dump
    output logic [1:0]  m_tuser    // [0] list_empty, [1] insert_dropped
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DUMP
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              drop_reg, drop_next;
    logic              sp_reg, sp_next;
    logic [ADDR_W-1:0] sdst_reg, sdst_next;
    logic              dv_reg, dv_next;
    logic              dlast_reg, dlast_next;
    logic              dempty_reg, dempty_next;
    logic              ddrop_reg, ddrop_next;
    logic [1:0]        fcnt_reg, fcnt_next;
    out_beat_t         f0_reg, f1_reg;

    logic [31:0]       mem [CAPACITY];
    logic [31:0]       rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              s_accept;
    logic              pop;
    logic [2:0]        occ;
    logic              issue_ok;
    cmd_t              cmd;
    logic [31:0]       opnd;
    logic              full;
    logic              pos_ok;
    logic [CNT_W-1:0]  pos_idx;
    logic [CNT_W-1:0]  idx_inc;
    out_beat_t         land;

    assign cmd      = cmd_t'(s_tdata[1:0]);
    assign opnd     = s_tdata[33:2];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign pos_ok   = opnd[31] ? (count_reg > CNT_W'(1)) : (opnd < 32'(count_reg));
    assign pos_idx  = opnd[31] ? CNT_W'(1) : opnd[CNT_W-1:0];
    assign idx_inc  = idx_reg + CNT_W'(1);

    assign m_tvalid = (fcnt_reg != 2'd0);
    assign m_tdata  = f0_reg.value;
    assign m_tlast  = f0_reg.last;
    assign m_tuser  = {f0_reg.dropped, f0_reg.empty};
    assign pop      = m_tvalid && m_tready;

    // Occupancy once the read in flight lands and this cycle's pop leaves.
    assign occ      = {1'b0, fcnt_reg} + {2'b0, dv_reg} - {2'b0, pop};
    assign issue_ok = (occ < 3'd2);

    assign land.value   = dempty_reg ? 32'd0 : rd_data_reg;
    assign land.last    = dlast_reg;
    assign land.empty   = dempty_reg;
    assign land.dropped = ddrop_reg;

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        drop_next   = drop_reg;
        sp_next     = 1'b0;
        sdst_next   = sdst_reg;
        dv_next     = 1'b0;
        dlast_next  = dlast_reg;
        dempty_next = dempty_reg;
        ddrop_next  = ddrop_reg;
        fcnt_next   = occ[1:0];
        rd_en       = 1'b0;
        rd_addr     = '0;
        // complete the pending move of a delete walk
        mem_we      = sp_reg;
        mem_waddr   = sdst_reg;
        mem_wdata   = rd_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    drop_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_DUMP;
                    unique case (cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                drop_next = 1'b1;
                            end else begin
                                head_next  = ring_dec(head_reg);
                                count_next = count_reg + CNT_W'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = ring_dec(head_reg);
                                mem_wdata  = opnd;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                drop_next = 1'b1;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = ring_add(head_reg, count_reg[ADDR_W-1:0]);
                                mem_wdata  = opnd;
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_ok) begin
                                if (pos_idx == '0) begin
                                    head_next  = ring_add(head_reg, ADDR_W'(1));
                                    count_next = count_reg - CNT_W'(1);
                                end else begin
                                    idx_next   = pos_idx;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        CMD_NOP: begin
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                if (idx_inc < count_reg) begin
                    rd_en     = 1'b1;
                    rd_addr   = ring_add(head_reg, idx_inc[ADDR_W-1:0]);
                    sp_next   = 1'b1;
                    sdst_next = ring_add(head_reg, idx_reg[ADDR_W-1:0]);
                    idx_next  = idx_inc;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    idx_next   = '0;
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (issue_ok) begin
                    dv_next     = 1'b1;
                    ddrop_next  = drop_reg;
                    dempty_next = (count_reg == '0);
                    dlast_next  = (count_reg == '0) || (idx_inc == count_reg);
                    rd_en       = (count_reg != '0);
                    rd_addr     = ring_add(head_reg, idx_reg[ADDR_W-1:0]);
                    idx_next    = idx_inc;
                    if ((count_reg == '0) || (idx_inc == count_reg)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
            sp_reg     <= 1'b0;
            dv_reg     <= 1'b0;
            fcnt_reg   <= 2'd0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            drop_reg   <= drop_next;
            sp_reg     <= sp_next;
            dv_reg     <= dv_next;
            fcnt_reg   <= fcnt_next;
        end
        sdst_reg   <= sdst_next;
        dlast_reg  <= dlast_next;
        dempty_reg <= dempty_next;
        ddrop_reg  <= ddrop_next;
        // drop the landing beat into the front slot if that slot frees up,
        // else advance the buffer on a pop and land behind it
        if (dv_reg && ((fcnt_reg - {1'b0, pop}) == 2'd0)) begin
            f0_reg <= land;
        end else if (pop) begin
            f0_reg <= f1_reg;
        end
        if (dv_reg && ((fcnt_reg - {1'b0, pop}) != 2'd0)) begin
            f1_reg <= land;
        end
    end

endmodule
